### src/cnb_pkg.sv
// Shared types and constants for the categorical naive Bayes unit.
package cnb_pkg;

  localparam int FEATURES   = 4;
  localparam int VALUE_BITS = 3;
  localparam int SCORE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_TRAIN    = 2'd1,
    CMD_CLASSIFY = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REQ_CLEAR,
    REQ_TRAIN,
    REQ_CLASSIFY
  } req_kind_t;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    req_kind_t                   kind;
    value_t [FEATURES-1:0]       values;
    logic                        label;
    logic                        in_range;
  } req_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] posterior_yes;
    logic [SCORE_BITS-1:0] posterior_no;
    logic                  yes_undefined;
    logic                  no_undefined;
    logic                  play_decision;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TR_READ,
    ST_TR_WRITE,
    ST_CL_READ,
    ST_CL_LATCH,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } back_state_t;

  typedef enum logic [4:0] {
    STP_T2,
    STP_T3,
    STP_A0_SQ,
    STP_A0_CU,
    STP_A1_SQ,
    STP_A1_CU,
    STP_P0_1,
    STP_P0_2,
    STP_P0_3,
    STP_P1_1,
    STP_P1_2,
    STP_P1_3,
    STP_D_1,
    STP_D_2,
    STP_D_3,
    STP_LHS,
    STP_RHS,
    STP_NUM_YES,
    STP_DEN_YES,
    STP_NUM_NO,
    STP_DEN_NO
  } step_t;

endpackage

### src/cnb_front.sv
// Front end: takes requests, drops ones with no effect, queues the rest.
module cnb_front #(
  parameter int VALUES_PER_FEATURE = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             command,
  input  logic [2:0]             outlook_value,
  input  logic [2:0]             temperature_value,
  input  logic [2:0]             humidity_value,
  input  logic [2:0]             wind_value,
  input  logic                   class_label,
  output logic                   req_valid,
  output cnb_pkg::req_t          req,
  input  logic                   req_pop
);
  import cnb_pkg::*;

  req_t       q [2];
  req_t       in_req;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       keep;
  logic       do_wr;

  always_comb begin
    in_req.values[0] = outlook_value;
    in_req.values[1] = temperature_value;
    in_req.values[2] = humidity_value;
    in_req.values[3] = wind_value;
    in_req.label     = class_label;
    in_req.in_range  = (32'(outlook_value) < VALUES_PER_FEATURE) &&
                       (32'(temperature_value) < VALUES_PER_FEATURE) &&
                       (32'(humidity_value) < VALUES_PER_FEATURE) &&
                       (32'(wind_value) < VALUES_PER_FEATURE);
    in_req.kind      = REQ_CLEAR;
    keep             = 1'b0;
    unique case (cmd_t'(command))
      CMD_CLEAR: begin
        in_req.kind = REQ_CLEAR;
        keep        = 1'b1;
      end
      CMD_TRAIN: begin
        in_req.kind = REQ_TRAIN;
        keep        = in_req.in_range;
      end
      CMD_CLASSIFY: begin
        in_req.kind = REQ_CLASSIFY;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = q[rptr];
  assign do_wr     = push && !full && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (req_pop) rptr <= ~rptr;
      count <= count + 2'(do_wr) - 2'(req_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) q[wptr] <= in_req;
  end

endmodule

### src/cnb_mul_seq.sv
// Shift-add multiplier, one multiplier bit per cycle, stops when no ones remain.
module cnb_mul_seq #(
  parameter int WB = 74,
  parameter int MB = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WB-1:0] a,
  input  logic [MB-1:0] b,
  output logic          done,
  output logic [WB-1:0] prod
);
  logic          busy;
  logic [WB-1:0] acc;
  logic [WB-1:0] ash;
  logic [MB-1:0] bsh;

  assign done = busy && (bsh == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= a;
      bsh <= b;
    end else if (busy && !done) begin
      if (bsh[0]) acc <= acc + ash;
      ash <= ash << 1;
      bsh <= bsh >> 1;
    end
  end

endmodule

### src/cnb_div_seq.sv
// Restoring divider, one quotient bit per cycle, 32-bit saturating quotient.
module cnb_div_seq #(
  parameter int WB = 74
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [WB+cnb_pkg::FRAC_BITS-1:0] num,
  input  logic [WB-1:0]                    den,
  output logic                             done,
  output logic [cnb_pkg::SCORE_BITS-1:0]   quot
);
  import cnb_pkg::*;

  localparam int NW = WB + FRAC_BITS + SCORE_BITS;
  localparam int CW = $clog2(SCORE_BITS);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [NW-1:0]         rem;
  logic [NW-1:0]         dsh;
  logic [SCORE_BITS-1:0] q;
  logic                  sat;

  assign quot = sat ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(SCORE_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(SCORE_BITS - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= NW'(num);
      dsh <= NW'(den) << (SCORE_BITS - 1);
      sat <= NW'(num) >= (NW'(den) << SCORE_BITS);
      q   <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[SCORE_BITS-2:0], 1'b1};
      end else begin
        q <= {q[SCORE_BITS-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

### src/cnb_back.sv
// Back end: count store, training updates and the classify sequencer.
module cnb_back #(
  parameter int VALUES_PER_FEATURE = 8,
  parameter int COUNT_BITS         = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  cnb_pkg::req_t     req,
  output logic              req_pop,
  output logic              res_valid,
  output cnb_pkg::result_t  res,
  input  logic              res_pop
);
  import cnb_pkg::*;

  localparam int ROWS = FEATURES * VALUES_PER_FEATURE;
  localparam int RW   = $clog2(ROWS);
  localparam int CB   = COUNT_BITS;
  localparam int TB   = CB + 1;
  localparam int MB   = 3 * CB + 3;
  localparam int WB   = 7 * CB + 4;

  back_state_t state, state_next;
  step_t       stp;
  logic [1:0]  fi;
  req_t        cur;

  logic [2*CB-1:0] row_mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [2*CB-1:0] rd_data;
  logic            rd_vld;
  logic [2*CB-1:0] rd_row;
  logic [2*CB-1:0] wr_data;
  logic [RW-1:0]   row_addr;
  logic [CB-1:0]   rd_n0, rd_n1;

  logic [CB-1:0] tot [2];
  logic [CB-1:0] cnt0 [FEATURES];
  logic [CB-1:0] cnt1 [FEATURES];
  logic [TB-1:0] sum  [FEATURES];
  logic [TB-1:0] tot_sum;

  logic [WB-1:0] t3, a0, a1, p0, p1, dd, lhs, rhs, num, den;

  logic          ev_ok, undef0, undef1;
  logic [WB-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [WB-1:0] mul_prod;
  logic          mul_done;
  logic [SCORE_BITS-1:0] quot;
  logic          div_done;
  logic [SCORE_BITS-1:0] score1;

  logic row_clear, mem_we, cl_latch, mul_start, mul_take, div_start, div_take, res_load;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] x);
    sat_inc = (x == '1) ? x : x + CB'(1);
  endfunction

  assign row_addr = cur.in_range ?
                    RW'(32'(fi) * VALUES_PER_FEATURE + 32'(cur.values[fi])) : '0;
  assign rd_row   = rd_vld ? rd_data : '0;
  assign rd_n0    = rd_row[CB-1:0];
  assign rd_n1    = rd_row[2*CB-1:CB];
  assign wr_data  = cur.label ? {sat_inc(rd_n1), rd_n0} : {rd_n1, sat_inc(rd_n0)};
  assign tot_sum  = TB'(tot[0]) + TB'(tot[1]);

  always_comb begin
    ev_ok = cur.in_range;
    for (int f = 0; f < FEATURES; f++) begin
      sum[f] = TB'(cnt0[f]) + TB'(cnt1[f]);
      if (sum[f] == '0) ev_ok = 1'b0;
    end
    undef0 = (tot[0] == '0) || !ev_ok;
    undef1 = (tot[1] == '0) || !ev_ok;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.kind)
            REQ_CLEAR:    state_next = ST_CLEAR;
            REQ_TRAIN:    state_next = ST_TR_READ;
            REQ_CLASSIFY: state_next = ST_CL_READ;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:    state_next = ST_IDLE;
      ST_TR_READ:  state_next = ST_TR_WRITE;
      ST_TR_WRITE: state_next = (fi == 2'd3) ? ST_IDLE : ST_TR_READ;
      ST_CL_READ:  state_next = ST_CL_LATCH;
      ST_CL_LATCH: state_next = (fi == 2'd3) ? ST_MUL_START : ST_CL_READ;
      ST_MUL_START: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (stp == STP_DEN_YES || stp == STP_DEN_NO) ? ST_DIV_START
                                                                 : ST_MUL_START;
        end
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = (stp == STP_DEN_NO) ? ST_DONE : ST_MUL_START;
      end
      ST_DONE: begin
        if (!res_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_pop   = (state == ST_IDLE) && req_valid;
    row_clear = (state == ST_CLEAR);
    mem_we    = (state == ST_TR_WRITE);
    cl_latch  = (state == ST_CL_LATCH);
    mul_start = (state == ST_MUL_START);
    mul_take  = (state == ST_MUL_WAIT) && mul_done;
    div_start = (state == ST_DIV_START);
    div_take  = (state == ST_DIV_WAIT) && div_done;
    res_load  = (state == ST_DONE) && !res_valid;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (stp)
      STP_T2:      begin mul_a = WB'(tot_sum); mul_b = MB'(tot_sum); end
      STP_T3:      begin mul_a = t3;           mul_b = MB'(tot_sum); end
      STP_A0_SQ:   begin mul_a = WB'(tot[0]);  mul_b = MB'(tot[0]);  end
      STP_A0_CU:   begin mul_a = a0;           mul_b = MB'(tot[0]);  end
      STP_A1_SQ:   begin mul_a = WB'(tot[1]);  mul_b = MB'(tot[1]);  end
      STP_A1_CU:   begin mul_a = a1;           mul_b = MB'(tot[1]);  end
      STP_P0_1:    begin mul_a = WB'(cnt0[0]); mul_b = MB'(cnt0[1]); end
      STP_P0_2:    begin mul_a = p0;           mul_b = MB'(cnt0[2]); end
      STP_P0_3:    begin mul_a = p0;           mul_b = MB'(cnt0[3]); end
      STP_P1_1:    begin mul_a = WB'(cnt1[0]); mul_b = MB'(cnt1[1]); end
      STP_P1_2:    begin mul_a = p1;           mul_b = MB'(cnt1[2]); end
      STP_P1_3:    begin mul_a = p1;           mul_b = MB'(cnt1[3]); end
      STP_D_1:     begin mul_a = WB'(sum[0]);  mul_b = MB'(sum[1]);  end
      STP_D_2:     begin mul_a = dd;           mul_b = MB'(sum[2]);  end
      STP_D_3:     begin mul_a = dd;           mul_b = MB'(sum[3]);  end
      STP_LHS:     begin mul_a = p1;           mul_b = a0[MB-1:0];   end
      STP_RHS:     begin mul_a = p0;           mul_b = a1[MB-1:0];   end
      STP_NUM_YES: begin mul_a = p1;           mul_b = t3[MB-1:0];   end
      STP_DEN_YES: begin mul_a = dd;           mul_b = a1[MB-1:0];   end
      STP_NUM_NO:  begin mul_a = p0;           mul_b = t3[MB-1:0];   end
      STP_DEN_NO:  begin mul_a = dd;           mul_b = a0[MB-1:0];   end
      default:     begin mul_a = '0;           mul_b = '0;           end
    endcase
  end

  cnb_mul_seq #(.WB(WB), .MB(MB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cnb_div_seq #(.WB(WB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({num, {FRAC_BITS{1'b0}}}),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fi        <= 2'd0;
      stp       <= STP_T2;
      res_valid <= 1'b0;
      row_valid <= '0;
      tot[0]    <= '0;
      tot[1]    <= '0;
    end else begin
      state <= state_next;
      if (req_pop) fi <= 2'd0;
      if (mem_we || cl_latch) fi <= fi + 2'd1;
      if (cl_latch && fi == 2'd3) stp <= STP_T2;
      if ((mul_take && stp != STP_DEN_YES && stp != STP_DEN_NO) || div_take) begin
        stp <= step_t'(stp + 5'd1);
      end
      if (row_clear) begin
        row_valid <= '0;
        tot[0]    <= '0;
        tot[1]    <= '0;
      end
      if (mem_we) begin
        row_valid[row_addr] <= 1'b1;
        if (fi == 2'd3) tot[cur.label] <= sat_inc(tot[cur.label]);
      end
      if (res_load) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= row_mem[row_addr];
    rd_vld  <= row_valid[row_addr];
    if (mem_we) row_mem[row_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (req_pop) cur <= req;
    if (cl_latch) begin
      cnt0[fi] <= rd_n0;
      cnt1[fi] <= rd_n1;
    end
    if (mul_take) begin
      case (stp)
        STP_T2, STP_T3:                 t3  <= mul_prod;
        STP_A0_SQ, STP_A0_CU:           a0  <= mul_prod;
        STP_A1_SQ, STP_A1_CU:           a1  <= mul_prod;
        STP_P0_1, STP_P0_2, STP_P0_3:   p0  <= mul_prod;
        STP_P1_1, STP_P1_2, STP_P1_3:   p1  <= mul_prod;
        STP_D_1, STP_D_2, STP_D_3:      dd  <= mul_prod;
        STP_LHS:                        lhs <= mul_prod;
        STP_RHS:                        rhs <= mul_prod;
        STP_NUM_YES, STP_NUM_NO:        num <= mul_prod;
        STP_DEN_YES, STP_DEN_NO:        den <= mul_prod;
        default:                        ;
      endcase
    end
    if (div_take && stp == STP_DEN_YES) score1 <= quot;
    if (res_load) begin
      res.posterior_yes <= undef1 ? '0 : score1;
      res.posterior_no  <= undef0 ? '0 : quot;
      res.yes_undefined <= undef1;
      res.no_undefined  <= undef0;
      res.play_decision <= !undef0 && !undef1 && (lhs > rhs);
    end
  end

endmodule

### src/categorical_naive_bayes_unit.sv
// Top level of the two-class categorical naive Bayes unit.
// Requests enter through a queue port: an item is taken on a clock edge with
// push high and full low. command 0 clears all counts, 1 trains one labelled
// row, 2 classifies; command 3 and training rows with a value out of range
// are dropped. Only classify requests make a result.
// Results leave through a queue port: the result shows while empty is low and
// is taken on an edge with pop high. A waiting result does not stop intake:
// a two-entry request queue sits in front of the engine, and the engine only
// stops when it has a new result and the old one is still not taken.
// Clear resets the counts; training does one read-modify-write per feature
// on the count store. Classify reads the counts of each feature, then runs 21
// products on one shift-add multiplier and two divisions.
// Reset clears the counts (per-row valid bits), the queues and the engine.
module categorical_naive_bayes_unit #(
  parameter int VALUES_PER_FEATURE = 8,
  parameter int COUNT_BITS         = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [2:0]  outlook_value,
  input  logic [2:0]  temperature_value,
  input  logic [2:0]  humidity_value,
  input  logic [2:0]  wind_value,
  input  logic        class_label,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] posterior_yes,
  output logic [31:0] posterior_no,
  output logic        yes_undefined,
  output logic        no_undefined,
  output logic        play_decision
);
  import cnb_pkg::*;

  logic    req_valid;
  req_t    req;
  logic    req_pop;
  logic    res_valid;
  result_t res;

  cnb_front #(.VALUES_PER_FEATURE(VALUES_PER_FEATURE)) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .command           (command),
    .outlook_value     (outlook_value),
    .temperature_value (temperature_value),
    .humidity_value    (humidity_value),
    .wind_value        (wind_value),
    .class_label       (class_label),
    .req_valid         (req_valid),
    .req               (req),
    .req_pop           (req_pop)
  );

  cnb_back #(
    .VALUES_PER_FEATURE (VALUES_PER_FEATURE),
    .COUNT_BITS         (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty         = !res_valid;
  assign posterior_yes = res.posterior_yes;
  assign posterior_no  = res.posterior_no;
  assign yes_undefined = res.yes_undefined;
  assign no_undefined  = res.no_undefined;
  assign play_decision = res.play_decision;

endmodule
